[rtl/core/d96_pkg.sv]
// Shared types and constants for the 96-bit decimal add/subtract unit.
package d96_pkg;

  localparam int WideBits  = 192;
  localparam int MantBits  = 96;
  localparam int MaxScale  = 28;
  localparam int ScaleBits = 5;
  localparam int CntBits   = $clog2(WideBits + 1);

  typedef logic [WideBits-1:0] wide_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LARGE = 2'd1,
    ST_SMALL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALIGN,
    S_CMP,
    S_ADD,
    S_CHECK,
    S_DIV,
    S_ROUND,
    S_DONE
  } state_t;

  // Command and status between the sequencer and the serial unit.
  typedef struct packed {
    logic start;   // begin one bit-serial pass
    logic [1:0] op; // operation selector
  } ser_cmd_t;

  localparam logic [1:0] OpMulA = 2'd0;
  localparam logic [1:0] OpMulB = 2'd1;
  localparam logic [1:0] OpAdd  = 2'd2;
  localparam logic [1:0] OpDiv  = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_sts_t;

endpackage

[rtl/core/d96_serial.sv]
// Bit-serial datapath: x10, add/subtract and divide by ten on 192-bit words.
module d96_serial (
  input  logic              clk,
  input  logic              rst_n,
  input  d96_pkg::ser_cmd_t cmd,
  input  logic              load,
  input  d96_pkg::wide_t    load_a,
  input  d96_pkg::wide_t    load_b,
  input  logic              sub,
  input  logic              swap,
  output d96_pkg::ser_sts_t sts,
  output d96_pkg::wide_t    a_out,
  output d96_pkg::wide_t    b_out,
  output d96_pkg::wide_t    r_out,
  output logic [3:0]        rem_out
);

  d96_pkg::wide_t a_r, a_nxt, b_r, b_nxt, r_r, r_nxt;
  logic [d96_pkg::CntBits-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [1:0] op_r, op_nxt;
  logic [3:0] car_r, car_nxt;   // carry for x10/add, remainder for /10
  logic [4:0] t;
  logic [4:0] rem2;
  logic xb, yb, qb;

  always_comb begin
    a_nxt = a_r; b_nxt = b_r; r_nxt = r_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    op_nxt = op_r; car_nxt = car_r;
    t = '0; rem2 = '0; xb = 1'b0; yb = 1'b0; qb = 1'b0;
    if (load) begin
      a_nxt = load_a;
      b_nxt = load_b;
    end else if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt = cmd.op;
      cnt_nxt = '0;
      car_nxt = (cmd.op == d96_pkg::OpAdd && sub) ? 4'd1 : 4'd0;
    end else if (busy_r) begin
      unique case (op_r)
        d96_pkg::OpMulA: begin
          // Each input bit contributes 10 to the running value; carry stays below 10.
          t = {1'b0, car_r} + (a_r[0] ? 5'd10 : 5'd0);
          a_nxt = {t[0], a_r[d96_pkg::WideBits-1:1]};
          car_nxt = t[4:1];
        end
        d96_pkg::OpMulB: begin
          t = {1'b0, car_r} + (b_r[0] ? 5'd10 : 5'd0);
          b_nxt = {t[0], b_r[d96_pkg::WideBits-1:1]};
          car_nxt = t[4:1];
        end
        d96_pkg::OpAdd: begin
          xb = swap ? b_r[0] : a_r[0];
          yb = (swap ? a_r[0] : b_r[0]) ^ sub;
          t = {4'd0, xb} + {4'd0, yb} + {1'b0, car_r};
          a_nxt = {a_r[0], a_r[d96_pkg::WideBits-1:1]};
          b_nxt = {b_r[0], b_r[d96_pkg::WideBits-1:1]};
          r_nxt = {t[0], r_r[d96_pkg::WideBits-1:1]};
          car_nxt = {3'd0, t[1]};
        end
        d96_pkg::OpDiv: begin
          // restoring long division, MSB first
          rem2 = {car_r, r_r[d96_pkg::WideBits-1]};
          qb = (rem2 >= 5'd10);
          car_nxt = qb ? 4'(rem2 - 5'd10) : rem2[3:0];
          r_nxt = {r_r[d96_pkg::WideBits-2:0], qb};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == d96_pkg::CntBits'(d96_pkg::WideBits - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= d96_pkg::OpMulA;
      car_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
      car_r  <= car_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    r_r <= r_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign a_out = a_r;
  assign b_out = b_r;
  assign r_out = r_r;
  assign rem_out = car_r;

  always_ff @(posedge clk) begin
    if (rst_n && done_r) begin
      assert (!busy_r) else $error("serial unit busy while reporting done");
    end
  end

  property p_start_busy;
    @(posedge clk) disable iff (!rst_n) (cmd.start && !load) |=> busy_r;
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("start did not begin a pass");

  property p_rem_range;
    @(posedge clk) disable iff (!rst_n) (busy_r && op_r == d96_pkg::OpDiv) |-> car_r < 4'd10;
  endproperty
  a_rem_range: assert property (p_rem_range) else $error("remainder out of range");

endmodule

[rtl/core/decimal96_add_sub_round.sv]
// Top level of the 96-bit sign-magnitude decimal add/subtract unit.
// Usage: one item enters on the in_ stream, one result leaves on the out_ stream. Work is
// bit serial over a 192-bit word: every multiply-by-ten alignment step, the add or subtract
// and every divide-by-ten step is one pass of the shared serial unit over all 192 bits, so
// an item takes 1 + |a_scale - b_scale| + k passes (up to 57 in the worst case), where k is
// the number of digits dropped to bring the sum into 96 bits. Only one item is in work at a
// time; the result sits in an output register while the next item is accepted, and a new
// result waits in the rounding step until that register is free.
module decimal96_add_sub_round (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[0], a_low[64:1], a_high[96:65], a_scale[101:97], a_sign[102],
  // b_low[166:103], b_high[198:167], b_scale[203:199], b_sign[204], zero fill
  input  logic [207:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // r_low[63:0], r_high[95:64], r_scale[100:96], r_sign[101], status[103:102]
  output logic [103:0] out_tdata
);

  d96_pkg::state_t st_r, st_nxt;
  d96_pkg::ser_cmd_t cmd;
  d96_pkg::ser_sts_t sts;
  d96_pkg::wide_t a_w, b_w, r_w, ld_a, ld_b;
  logic [3:0] rem;
  logic [4:0] sa_r, sa_nxt, sb_r, sb_nxt;
  logic [4:0] sa_in, sb_in;
  logic as_r, as_nxt, bs_r, bs_nxt;   // b sign already folded with action
  logic swap_r, swap_nxt, sign_r, sign_nxt;
  logic [3:0] d_r, d_nxt;
  logic stk_r, stk_nxt;
  logic pend_r, pend_nxt;             // an alignment pass is running
  logic load;
  logic [96:0] inc;
  logic up, fits, out_free;
  logic [103:0] res_r, res_nxt;
  logic [95:0] lo96;
  logic [1:0] status;
  logic ovalid_r, ovalid_nxt;

  assign sa_in = (in_tdata[101:97] > 5'(d96_pkg::MaxScale)) ? 5'(d96_pkg::MaxScale)
                                                            : in_tdata[101:97];
  assign sb_in = (in_tdata[203:199] > 5'(d96_pkg::MaxScale)) ? 5'(d96_pkg::MaxScale)
                                                             : in_tdata[203:199];
  assign ld_a = {96'd0, in_tdata[96:1]};
  assign ld_b = {96'd0, in_tdata[198:103]};
  assign in_tready = (st_r == d96_pkg::S_IDLE);
  assign load = in_tvalid && in_tready;
  // The output register may take a new result when it is empty or once the waiting one leaves.
  assign out_free = !ovalid_r || out_tready;
  assign fits = (r_w[d96_pkg::WideBits-1:d96_pkg::MantBits] == '0);
  assign up = (d_r > 4'd5) || (d_r == 4'd5 && (stk_r || r_w[0]));
  assign inc = {1'b0, r_w[95:0]} + {96'd0, up};

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      d96_pkg::S_IDLE:  if (load) st_nxt = d96_pkg::S_ALIGN;
      d96_pkg::S_ALIGN: if (!pend_r && sa_r == sb_r) st_nxt = d96_pkg::S_CMP;
      d96_pkg::S_CMP:   st_nxt = d96_pkg::S_ADD;
      d96_pkg::S_ADD:   if (sts.done) st_nxt = d96_pkg::S_CHECK;
      d96_pkg::S_CHECK: st_nxt = (!fits && sa_r != '0) ? d96_pkg::S_DIV : d96_pkg::S_ROUND;
      d96_pkg::S_DIV:   if (sts.done) st_nxt = d96_pkg::S_CHECK;
      d96_pkg::S_ROUND: if (out_free) st_nxt = d96_pkg::S_DONE;
      d96_pkg::S_DONE:  st_nxt = d96_pkg::S_IDLE;
      default:          st_nxt = d96_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    cmd = '0;
    sa_nxt = sa_r; sb_nxt = sb_r; as_nxt = as_r; bs_nxt = bs_r;
    swap_nxt = swap_r; sign_nxt = sign_r; d_nxt = d_r; stk_nxt = stk_r;
    pend_nxt = pend_r; res_nxt = res_r;
    lo96 = '0; status = d96_pkg::ST_OK;
    unique case (st_r)
      d96_pkg::S_IDLE: begin
        if (load) begin
          sa_nxt = sa_in; sb_nxt = sb_in;
          as_nxt = in_tdata[102];
          bs_nxt = in_tdata[204] ^ in_tdata[0];
          d_nxt = '0; stk_nxt = 1'b0; pend_nxt = 1'b0;
        end
      end
      d96_pkg::S_ALIGN: begin
        if (pend_r) begin
          if (sts.done) pend_nxt = 1'b0;
        end else if (sa_r < sb_r) begin
          cmd.start = 1'b1; cmd.op = d96_pkg::OpMulA;
          sa_nxt = sa_r + 5'd1; pend_nxt = 1'b1;
        end else if (sb_r < sa_r) begin
          cmd.start = 1'b1; cmd.op = d96_pkg::OpMulB;
          sb_nxt = sb_r + 5'd1; pend_nxt = 1'b1;
        end
      end
      d96_pkg::S_CMP: begin
        swap_nxt = (a_w < b_w);
        sign_nxt = (a_w < b_w) ? bs_r : as_r;
        cmd.start = 1'b1; cmd.op = d96_pkg::OpAdd;
      end
      d96_pkg::S_CHECK: begin
        if (!fits && sa_r != '0) begin
          if (d_r != '0) stk_nxt = 1'b1;
          cmd.start = 1'b1; cmd.op = d96_pkg::OpDiv;
          sa_nxt = sa_r - 5'd1;
        end
      end
      d96_pkg::S_DIV: begin
        if (sts.done) d_nxt = rem;
      end
      d96_pkg::S_ROUND: begin
        lo96 = inc[95:0];
        status = sign_r ? d96_pkg::ST_SMALL : d96_pkg::ST_LARGE;
        if (out_free) begin
          if (!fits || inc[96]) begin
            res_nxt = {status, 102'd0};
          end else begin
            res_nxt = {d96_pkg::ST_OK, sign_r && (lo96 != '0), sa_r, lo96};
          end
        end
      end
      default: ;
    endcase
  end

  d96_serial u_ser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .load    (load),
    .load_a  (ld_a),
    .load_b  (ld_b),
    .sub     (as_r != bs_r),
    .swap    (swap_r),
    .sts     (sts),
    .a_out   (a_w),
    .b_out   (b_w),
    .r_out   (r_w),
    .rem_out (rem)
  );

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_tvalid && out_tready) ovalid_nxt = 1'b0;
    if (st_r == d96_pkg::S_DONE) ovalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= d96_pkg::S_IDLE;
      ovalid_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ovalid_r <= ovalid_nxt;
      pend_r <= pend_nxt;
    end
    sa_r <= sa_nxt; sb_r <= sb_nxt; as_r <= as_nxt; bs_r <= bs_nxt;
    swap_r <= swap_nxt; sign_r <= sign_nxt; d_r <= d_nxt; stk_r <= stk_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = res_r;

  property p_one_in_flight;
    @(posedge clk) disable iff (!rst_n) load |-> st_r == d96_pkg::S_IDLE;
  endproperty
  a_one_in_flight: assert property (p_one_in_flight) else $error("item accepted while busy");

  property p_scale_ok;
    @(posedge clk) disable iff (!rst_n)
      (st_r == d96_pkg::S_ROUND) |-> sa_r <= 5'(d96_pkg::MaxScale);
  endproperty
  a_scale_ok: assert property (p_scale_ok) else $error("result scale out of range");

  property p_done_valid;
    @(posedge clk) disable iff (!rst_n) (st_r == d96_pkg::S_DONE) |=> out_tvalid;
  endproperty
  a_done_valid: assert property (p_done_valid) else $error("result not presented");

endmodule
